### src/bbn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbn_pkg
// Shared types and fixed-point constants of the bump basis normal pipeline.
// ---------------------------------------------------------------------------
package bbn_pkg;

    // signed Q1.14 component and signed Q.30 unit component
    localparam int COMP_W = 16;
    localparam int UNIT_W = 32;
    localparam int FRAC   = 30;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [UNIT_W-1:0] unit_t;
    typedef comp_t [2:0] cvec_t;
    typedef unit_t [2:0] uvec_t;

    // local basis coefficients, Q.30 rounded to nearest
    localparam unit_t K_SQRT_TWO_THIRDS = 32'sd876706528;
    localparam unit_t K_INV_SQRT_SIX    = 32'sd438353264;
    localparam unit_t K_INV_SQRT_TWO    = 32'sd759250125;
    localparam unit_t K_INV_SQRT_THREE  = 32'sd619925131;

    // one in Q.30
    localparam unit_t UNIT_ONE = unit_t'(1) <<< FRAC;

endpackage
`default_nettype wire

### src/bbn_cross.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbn_cross
// Two-stage exact integer cross product a x b with a sideband carried along.
// ---------------------------------------------------------------------------
module bbn_cross #(
    parameter int AW = 16,
    parameter int BW = 16,
    parameter int TW = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][AW-1:0]      a,
    input  logic [2:0][BW-1:0]      b,
    input  logic [TW-1:0]           tag_in,
    output logic                    out_valid,
    output logic [2:0][AW+BW:0]     c,
    output logic [TW-1:0]           tag_out
);

    localparam int PW = AW + BW;

    logic [5:0][PW-1:0] prod_reg, prod_next;
    logic [2:0][PW:0]   c_reg, c_next;
    logic [TW-1:0]      p1_tag_reg, p2_tag_reg;
    logic               p1_valid_reg, p2_valid_reg;

    // six partial products
    always_comb
    begin
        prod_next[0] = $signed(a[1]) * $signed(b[2]);
        prod_next[1] = $signed(a[2]) * $signed(b[1]);
        prod_next[2] = $signed(a[2]) * $signed(b[0]);
        prod_next[3] = $signed(a[0]) * $signed(b[2]);
        prod_next[4] = $signed(a[0]) * $signed(b[1]);
        prod_next[5] = $signed(a[1]) * $signed(b[0]);
    end

    // pairwise differences
    always_comb
    begin
        c_next[0] = $signed(prod_reg[0]) - $signed(prod_reg[1]);
        c_next[1] = $signed(prod_reg[2]) - $signed(prod_reg[3]);
        c_next[2] = $signed(prod_reg[4]) - $signed(prod_reg[5]);
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= in_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg   <= prod_next;
            p1_tag_reg <= tag_in;
            c_reg      <= c_next;
            p2_tag_reg <= p1_tag_reg;
        end
    end

    assign out_valid = p2_valid_reg;
    assign c         = c_reg;
    assign tag_out   = p2_tag_reg;

endmodule
`default_nettype wire

### src/bbn_norm.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbn_norm
// Pipelined vector normalizer: magnitude prescale, sum of squares, one
// square-root digit per stage, one quotient bit per stage, Q.30 unit out.
// ---------------------------------------------------------------------------
module bbn_norm #(
    parameter int IW = 33,
    parameter int TW = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2:0][IW-1:0]  c,
    input  logic [TW-1:0]       tag_in,
    output logic                out_valid,
    output bbn_pkg::uvec_t      u,
    output logic [TW-1:0]       tag_out
);

    import bbn_pkg::*;

    localparam int MW         = UNIT_W - 1;     // prescaled magnitude width
    localparam int KW         = $clog2(IW);
    localparam int SQ_W       = 2 * MW + 2;     // sum of squares width
    localparam int LW         = MW + 1;         // length width
    localparam int NW         = MW + FRAC + 1;  // dividend width
    localparam int SQRT_STEPS = SQ_W / 2;
    localparam int DIV_STEPS  = MW;

    // stage 0: magnitudes and signs
    logic [2:0][IW-1:0] s0_mag_reg, s0_mag_next;
    logic [2:0]         s0_neg_reg;
    logic [TW-1:0]      s0_tag_reg;
    logic               s0_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s0_mag_next[i] = c[i][IW-1] ? (~c[i] + 1'b1) : c[i];
        end
    end

    // stage 1: common right shift that brings all magnitudes below 2^31
    logic [IW-1:0]      mag_or;
    logic [KW-1:0]      shift_k;
    logic [2:0][MW-1:0] s1_m_reg, s1_m_next;
    logic [2:0]         s1_neg_reg;
    logic [TW-1:0]      s1_tag_reg;
    logic               s1_valid_reg;

    always_comb
    begin
        mag_or  = s0_mag_reg[0] | s0_mag_reg[1] | s0_mag_reg[2];
        shift_k = '0;
        for (int j = MW; j < IW; j++)
        begin
            if (mag_or[j])
            begin
                shift_k = KW'(j - MW + 1);
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            s1_m_next[i] = MW'(s0_mag_reg[i] >> shift_k);
        end
    end

    // stage 2: squares
    logic [2:0][2*MW-1:0] s2_sq_reg, s2_sq_next;
    logic [2:0][MW-1:0]   s2_m_reg;
    logic [2:0]           s2_neg_reg;
    logic [TW-1:0]        s2_tag_reg;
    logic                 s2_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            s2_sq_next[i] = s1_m_reg[i] * s1_m_reg[i];
        end
    end

    // stage 3: sum of squares feeds the root chain at index zero
    logic [SQ_W-1:0] sum_next;

    assign sum_next = SQ_W'(s2_sq_reg[0]) + SQ_W'(s2_sq_reg[1]) + SQ_W'(s2_sq_reg[2]);

    logic [SQ_W-1:0]     rt_v_reg   [SQRT_STEPS+1];
    logic [SQ_W-1:0]     rt_r_reg   [SQRT_STEPS+1];
    logic [2:0][MW-1:0]  rt_m_reg   [SQRT_STEPS+1];
    logic [2:0]          rt_neg_reg [SQRT_STEPS+1];
    logic [TW-1:0]       rt_tag_reg [SQRT_STEPS+1];
    logic                rt_valid_reg [SQRT_STEPS+1];

    // front stages, valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg    <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            rt_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg    <= in_valid;
            s1_valid_reg    <= s0_valid_reg;
            s2_valid_reg    <= s1_valid_reg;
            rt_valid_reg[0] <= s2_valid_reg;
        end
    end

    // front stages, payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_mag_reg    <= s0_mag_next;
            s0_neg_reg    <= {c[2][IW-1], c[1][IW-1], c[0][IW-1]};
            s0_tag_reg    <= tag_in;
            s1_m_reg      <= s1_m_next;
            s1_neg_reg    <= s0_neg_reg;
            s1_tag_reg    <= s0_tag_reg;
            s2_sq_reg     <= s2_sq_next;
            s2_m_reg      <= s1_m_reg;
            s2_neg_reg    <= s1_neg_reg;
            s2_tag_reg    <= s1_tag_reg;
            rt_v_reg[0]   <= sum_next;
            rt_r_reg[0]   <= '0;
            rt_m_reg[0]   <= s2_m_reg;
            rt_neg_reg[0] <= s2_neg_reg;
            rt_tag_reg[0] <= s2_tag_reg;
        end
    end

    // integer square root, one result bit per stage
    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_sqrt
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * i);
        logic [SQ_W-1:0] trial, v_next, r_next;

        always_comb
        begin
            trial = rt_r_reg[i] + BIT;
            if (rt_v_reg[i] >= trial)
            begin
                v_next = rt_v_reg[i] - trial;
                r_next = (rt_r_reg[i] >> 1) + BIT;
            end
            else
            begin
                v_next = rt_v_reg[i];
                r_next = rt_r_reg[i] >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rt_valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                rt_valid_reg[i+1] <= rt_valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rt_v_reg[i+1]   <= v_next;
                rt_r_reg[i+1]   <= r_next;
                rt_m_reg[i+1]   <= rt_m_reg[i];
                rt_neg_reg[i+1] <= rt_neg_reg[i];
                rt_tag_reg[i+1] <= rt_tag_reg[i];
            end
        end
    end

    // divider setup: dividend = m * 2^30 + len / 2
    logic [LW-1:0]          len;
    logic [2:0][NW-1:0]     dividend;

    assign len = rt_r_reg[SQRT_STEPS][LW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dividend[i] = {rt_m_reg[SQRT_STEPS][i], FRAC'(0)} + NW'(len >> 1);
        end
    end

    logic [2:0][LW-1:0]        dv_rem_reg  [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] dv_low_reg  [DIV_STEPS+1];
    logic [2:0][DIV_STEPS-1:0] dv_q_reg    [DIV_STEPS+1];
    logic [LW-1:0]             dv_len_reg  [DIV_STEPS+1];
    logic                      dv_zero_reg [DIV_STEPS+1];
    logic [2:0]                dv_neg_reg  [DIV_STEPS+1];
    logic [TW-1:0]             dv_tag_reg  [DIV_STEPS+1];
    logic                      dv_valid_reg [DIV_STEPS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_valid_reg[0] <= rt_valid_reg[SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[0][i] <= LW'(dividend[i][NW-1:DIV_STEPS]);
                dv_low_reg[0][i] <= dividend[i][DIV_STEPS-1:0];
            end
            dv_q_reg[0]    <= '0;
            dv_len_reg[0]  <= len;
            dv_zero_reg[0] <= (len == '0);
            dv_neg_reg[0]  <= rt_neg_reg[SQRT_STEPS];
            dv_tag_reg[0]  <= rt_tag_reg[SQRT_STEPS];
        end
    end

    // restoring division, one quotient bit per stage for all three lanes
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        logic [2:0][LW-1:0]        rem_next;
        logic [2:0][DIV_STEPS-1:0] low_next, q_next;

        always_comb
        begin
            logic [LW:0] part;
            logic        take;
            for (int i = 0; i < 3; i++)
            begin
                part = {dv_rem_reg[j][i], dv_low_reg[j][i][DIV_STEPS-1]};
                take = (part >= {1'b0, dv_len_reg[j]});
                rem_next[i] = take ? LW'(part - {1'b0, dv_len_reg[j]}) : LW'(part);
                low_next[i] = dv_low_reg[j][i] << 1;
                q_next[i]   = {dv_q_reg[j][i][DIV_STEPS-2:0], take};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_valid_reg[j+1] <= dv_valid_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j+1]  <= rem_next;
                dv_low_reg[j+1]  <= low_next;
                dv_q_reg[j+1]    <= q_next;
                dv_len_reg[j+1]  <= dv_len_reg[j];
                dv_zero_reg[j+1] <= dv_zero_reg[j];
                dv_neg_reg[j+1]  <= dv_neg_reg[j];
                dv_tag_reg[j+1]  <= dv_tag_reg[j];
            end
        end
    end

    // clamp, restore sign, zero-length vector gives zero
    uvec_t          u_reg, u_next;
    logic [TW-1:0]  out_tag_reg;
    logic           out_valid_reg;

    always_comb
    begin
        logic [UNIT_W-1:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = {1'b0, dv_q_reg[DIV_STEPS][i]};
            if (qc > UNIT_ONE)
            begin
                qc = UNIT_ONE;
            end
            if (dv_zero_reg[DIV_STEPS])
            begin
                u_next[i] = '0;
            end
            else if (dv_neg_reg[DIV_STEPS][i])
            begin
                u_next[i] = -qc;
            end
            else
            begin
                u_next[i] = qc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg       <= u_next;
            out_tag_reg <= dv_tag_reg[DIV_STEPS];
        end
    end

    assign out_valid = out_valid_reg;
    assign u         = u_reg;
    assign tag_out   = out_tag_reg;

endmodule
`default_nettype wire

### src/bbn_blend.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bbn_blend
// Maps the three local basis vectors onto (a2, a1, phong), rounds the Q.60
// sums to Q1.14 and saturates. Three register stages.
// ---------------------------------------------------------------------------
module bbn_blend (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  bbn_pkg::uvec_t          a1,
    input  bbn_pkg::uvec_t          a2,
    input  bbn_pkg::cvec_t          ph,
    input  logic                    left,
    output logic                    out_valid,
    output bbn_pkg::cvec_t [2:0]    n,
    output logic                    out_left
);

    import bbn_pkg::*;

    localparam int PRW   = 2 * UNIT_W - 2;
    localparam int ACW   = 2 * UNIT_W;
    localparam int SHIFT = 2 * FRAC - (COMP_W - 2);
    localparam logic signed [ACW-1:0] RND    = ACW'(1) <<< (SHIFT - 1);
    localparam logic signed [ACW-1:0] SAT_HI = (ACW'(1) <<< (COMP_W - 1)) - 1;
    localparam logic signed [ACW-1:0] SAT_LO = -(ACW'(1) <<< (COMP_W - 1));

    // stage 0: shared products
    logic signed [PRW-1:0] pa_reg [3];
    logic signed [PRW-1:0] pb_reg [3];
    logic signed [PRW-1:0] py_reg [3];
    logic signed [PRW-1:0] pz_reg [3];
    logic                  p_left_reg, p_valid_reg;

    // stage 1: the nine sums
    logic signed [ACW-1:0] acc_reg [3][3];
    logic signed [ACW-1:0] acc_next [3][3];
    logic                  a_left_reg, a_valid_reg;

    always_comb
    begin
        logic signed [ACW-1:0] yt, zt, xb;
        for (int i = 0; i < 3; i++)
        begin
            yt = ACW'(py_reg[i]);
            if (p_left_reg)
            begin
                yt = -yt;
            end
            zt = ACW'(pz_reg[i]) <<< COMP_W;
            xb = ACW'(pb_reg[i]);
            acc_next[0][i] = ACW'(pa_reg[i]) + zt;
            acc_next[1][i] = zt - xb + yt;
            acc_next[2][i] = zt - xb - yt;
        end
    end

    // stage 2: round to Q1.14 and saturate
    cvec_t [2:0] n_reg, n_next;
    logic        o_left_reg, o_valid_reg;

    always_comb
    begin
        logic signed [ACW-1:0] r;
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                r = (acc_reg[j][i] + RND) >>> SHIFT;
                priority if (r > SAT_HI)
                begin
                    n_next[j][i] = SAT_HI[COMP_W-1:0];
                end
                else if (r < SAT_LO)
                begin
                    n_next[j][i] = SAT_LO[COMP_W-1:0];
                end
                else
                begin
                    n_next[j][i] = r[COMP_W-1:0];
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= in_valid;
            a_valid_reg <= p_valid_reg;
            o_valid_reg <= a_valid_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= $signed(a2[i]) * K_SQRT_TWO_THIRDS;
                pb_reg[i] <= $signed(a2[i]) * K_INV_SQRT_SIX;
                py_reg[i] <= $signed(a1[i]) * K_INV_SQRT_TWO;
                pz_reg[i] <= $signed(ph[i]) * K_INV_SQRT_THREE;
            end
            p_left_reg <= left;
            acc_reg    <= acc_next;
            a_left_reg <= p_left_reg;
            n_reg      <= n_next;
            o_left_reg <= a_left_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign n         = n_reg;
    assign out_left  = o_left_reg;

endmodule
`default_nettype wire

### src/bump_basis_normals.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bump_basis_normals
// Radiosity normal-mapping basis: three bump normals and handedness per
// vertex or texel, fully pipelined.
// ---------------------------------------------------------------------------
// One word in and one word out per cycle while the output word is taken,
// with no gaps between words. Stages in order: handedness (cross product
// and dot product), first cross product, first normalizer (4 prescale and
// square stages, 32 square-root stages, 1 divider setup, 31 divider
// stages, 1 sign stage), second cross product, second normalizer, blend.
// The whole pipeline moves on one enable; when the output word is not taken,
// every stage holds and s_axis_tready drops in the same cycle.
module bump_basis_normals (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // s_x, s_y, s_z, t_x, t_y, t_z, flat_x, flat_y, flat_z,
    // smooth_x, smooth_y, smooth_z
    input  logic [191:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // n0_x, n0_y, n0_z, n1_x, n1_y, n1_z, n2_x, n2_y, n2_z
    output logic [143:0]  m_axis_tdata,
    // left_handed
    output logic          m_axis_tuser
);

    import bbn_pkg::*;

    typedef struct packed {
        cvec_t fl;
        cvec_t ph;
        cvec_t s;
    } hx_tag_t;

    typedef struct packed {
        logic  left;
        cvec_t ph;
    } c1_tag_t;

    typedef struct packed {
        logic  left;
        cvec_t ph;
        uvec_t a1;
    } c2_tag_t;

    localparam int CW   = 2 * COMP_W + 1;
    localparam int DPW  = COMP_W + CW;
    localparam int DOTW = DPW + 2;
    localparam int C2W  = UNIT_W + COMP_W + 1;

    logic en;

    // whole pipeline advances unless the output word is held
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // input unpacking
    cvec_t   in_s, in_t, in_fl, in_ph;
    hx_tag_t hx_tag_in;

    assign in_s  = s_axis_tdata[47:0];
    assign in_t  = s_axis_tdata[95:48];
    assign in_fl = s_axis_tdata[143:96];
    assign in_ph = s_axis_tdata[191:144];
    assign hx_tag_in = '{fl: in_fl, ph: in_ph, s: in_s};

    // s x t for handedness
    logic              hx_valid;
    logic [2:0][CW-1:0] st;
    hx_tag_t           hx_tag;

    bbn_cross #(
        .AW (COMP_W),
        .BW (COMP_W),
        .TW ($bits(hx_tag_t))
    ) u_cross_st (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .a         (in_s),
        .b         (in_t),
        .tag_in    (hx_tag_in),
        .out_valid (hx_valid),
        .c         (st),
        .tag_out   (hx_tag)
    );

    // dot(flat, s x t): products, then sum and sign
    logic [2:0][DPW-1:0] dp_prod_reg, dp_prod_next;
    cvec_t               dp_ph_reg, dp_s_reg;
    logic                dp_valid_reg;
    logic signed [DOTW-1:0] dot_sum;
    logic                hd_left_reg;
    cvec_t               hd_ph_reg, hd_s_reg;
    logic                hd_valid_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dp_prod_next[i] = $signed(hx_tag.fl[i]) * $signed(st[i]);
        end
    end

    assign dot_sum = $signed(dp_prod_reg[0]) + $signed(dp_prod_reg[1])
                   + $signed(dp_prod_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_valid_reg <= 1'b0;
            hd_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            dp_valid_reg <= hx_valid;
            hd_valid_reg <= dp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dp_prod_reg <= dp_prod_next;
            dp_ph_reg   <= hx_tag.ph;
            dp_s_reg    <= hx_tag.s;
            hd_left_reg <= dot_sum[DOTW-1];
            hd_ph_reg   <= dp_ph_reg;
            hd_s_reg    <= dp_s_reg;
        end
    end

    // phong x s
    c1_tag_t             c1_tag_in, c1_tag;
    logic                c1_valid;
    logic [2:0][CW-1:0]  c1;

    assign c1_tag_in = '{left: hd_left_reg, ph: hd_ph_reg};

    bbn_cross #(
        .AW (COMP_W),
        .BW (COMP_W),
        .TW ($bits(c1_tag_t))
    ) u_cross_c1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (hd_valid_reg),
        .a         (hd_ph_reg),
        .b         (hd_s_reg),
        .tag_in    (c1_tag_in),
        .out_valid (c1_valid),
        .c         (c1),
        .tag_out   (c1_tag)
    );

    // a1 = normalize(phong x s)
    logic    a1_valid;
    uvec_t   a1;
    c1_tag_t a1_tag;

    bbn_norm #(
        .IW (CW),
        .TW ($bits(c1_tag_t))
    ) u_norm_a1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c1_valid),
        .c         (c1),
        .tag_in    (c1_tag),
        .out_valid (a1_valid),
        .u         (a1),
        .tag_out   (a1_tag)
    );

    // a1 x phong
    c2_tag_t              c2_tag_in, c2_tag;
    logic                 c2_valid;
    logic [2:0][C2W-1:0]  c2;

    assign c2_tag_in = '{left: a1_tag.left, ph: a1_tag.ph, a1: a1};

    bbn_cross #(
        .AW (UNIT_W),
        .BW (COMP_W),
        .TW ($bits(c2_tag_t))
    ) u_cross_c2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a1_valid),
        .a         (a1),
        .b         (a1_tag.ph),
        .tag_in    (c2_tag_in),
        .out_valid (c2_valid),
        .c         (c2),
        .tag_out   (c2_tag)
    );

    // a2 = normalize(a1 x phong)
    logic    a2_valid;
    uvec_t   a2;
    c2_tag_t a2_tag;

    bbn_norm #(
        .IW (C2W),
        .TW ($bits(c2_tag_t))
    ) u_norm_a2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid),
        .c         (c2),
        .tag_in    (c2_tag),
        .out_valid (a2_valid),
        .u         (a2),
        .tag_out   (a2_tag)
    );

    // basis mapping and output register
    cvec_t [2:0] n_out;

    bbn_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a2_valid),
        .a1        (a2_tag.a1),
        .a2        (a2),
        .ph        (a2_tag.ph),
        .left      (a2_tag.left),
        .out_valid (m_axis_tvalid),
        .n         (n_out),
        .out_left  (m_axis_tuser)
    );

    assign m_axis_tdata = n_out;

    // a1 never exceeds unit length in any component
    a_a1_unit: assert property (@(posedge clk) disable iff (!rst_n)
        a1_valid |-> ($signed(a1[0]) <= UNIT_ONE && $signed(a1[0]) >= -UNIT_ONE
                   && $signed(a1[1]) <= UNIT_ONE && $signed(a1[1]) >= -UNIT_ONE
                   && $signed(a1[2]) <= UNIT_ONE && $signed(a1[2]) >= -UNIT_ONE))
        else $error("a1 component beyond unit length");

    // a2 never exceeds unit length in any component
    a_a2_unit: assert property (@(posedge clk) disable iff (!rst_n)
        a2_valid |-> ($signed(a2[0]) <= UNIT_ONE && $signed(a2[0]) >= -UNIT_ONE
                   && $signed(a2[1]) <= UNIT_ONE && $signed(a2[1]) >= -UNIT_ONE
                   && $signed(a2[2]) <= UNIT_ONE && $signed(a2[2]) >= -UNIT_ONE))
        else $error("a2 component beyond unit length");

    // a1 x phong stays exactly orthogonal to the phong normal it travels with
    a_c2_ortho: assert property (@(posedge clk) disable iff (!rst_n)
        c2_valid |-> ((64'($signed(c2[0])) * 64'($signed(c2_tag.ph[0]))
                     + 64'($signed(c2[1])) * 64'($signed(c2_tag.ph[1]))
                     + 64'($signed(c2[2])) * 64'($signed(c2_tag.ph[2]))) == 64'sd0))
        else $error("second cross product not orthogonal to phong normal");

endmodule
`default_nettype wire
